/* sv/state_space_step_defines.svh */
// Assertion macros shared by the state-space step checker.
`ifndef STATE_SPACE_STEP_DEFINES_SVH
`define STATE_SPACE_STEP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sss_pkg.sv */
// Types, constants and helper functions of the state-space step block.
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

  localparam int MAX_STATES    = 8;
  localparam int MAX_INPUTS    = 4;
  localparam int MAX_OUTPUTS   = 4;
  localparam int VALUE_BITS    = 32;
  localparam int FRACTION_BITS = 16;

  localparam int FIELD_BITS = 32;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 2;

  localparam int MAX_SI  = (MAX_STATES > MAX_INPUTS) ? MAX_STATES : MAX_INPUTS;
  localparam int MAX_DIM = (MAX_SI > MAX_OUTPUTS) ? MAX_SI : MAX_OUTPUTS;
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int IX_W    = $clog2(MAX_DIM);
  localparam int XI_W    = $clog2(MAX_STATES);
  localparam int UI_W    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  localparam int COEF_A_BASE = 0;
  localparam int COEF_B_BASE = COEF_A_BASE + MAX_STATES * MAX_STATES;
  localparam int COEF_C_BASE = COEF_B_BASE + MAX_STATES * MAX_INPUTS;
  localparam int COEF_D_BASE = COEF_C_BASE + MAX_OUTPUTS * MAX_STATES;
  localparam int COEF_DEPTH  = COEF_D_BASE + MAX_OUTPUTS * MAX_INPUTS;
  localparam int CA_W        = $clog2(COEF_DEPTH);

  localparam int ACC_W = 2 * VALUE_BITS + $clog2(MAX_STATES + MAX_INPUTS) + 1;

  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]      SAT_HI  = ACC_W'(VAL_MAX);
  localparam logic signed [ACC_W-1:0]      SAT_LO  = ACC_W'(VAL_MIN);

  localparam logic [1:0] OP_COEF   = 2'd0;
  localparam logic [1:0] OP_STATE  = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic [1:0] MAT_A = 2'd0;
  localparam logic [1:0] MAT_B = 2'd1;
  localparam logic [1:0] MAT_C = 2'd2;
  localparam logic [1:0] MAT_D = 2'd3;

  localparam logic KIND_Y = 1'b0;
  localparam logic KIND_X = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH,
    ST_EMIT,
    ST_COMMIT
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]                   opcode;
    logic [1:0]                   matrix_select;
    logic [2:0]                   row;
    logic [2:0]                   col;
    logic signed [FIELD_BITS-1:0] value;
    logic                         last_input;
  } in_item_t;

  typedef struct packed {
    logic                         result_kind;
    logic [2:0]                   result_index;
    logic signed [FIELD_BITS-1:0] result_value;
    logic                         saturated;
    logic                         result_last;
  } out_item_t;

  typedef struct packed {
    logic            accept;
    logic            issue;
    logic            clear;
    logic            kind;
    logic [IX_W-1:0] row;
    logic [IX_W-1:0] term;
    logic            phase_in;
    logic            finish;
    logic            emit;
    logic            last;
    logic            commit;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] m;
    logic [CNT_W-1:0] p;
    logic             out_free;
  } dp_stat_t;

  // Flat address of one coefficient in the shared coefficient memory.
  function automatic logic [CA_W-1:0] coef_addr(input logic [1:0] sel,
                                                input int unsigned r,
                                                input int unsigned c);
    int unsigned a;
    case (sel)
      MAT_A:   a = COEF_A_BASE + r * MAX_STATES + c;
      MAT_B:   a = COEF_B_BASE + r * MAX_INPUTS + c;
      MAT_C:   a = COEF_C_BASE + r * MAX_STATES + c;
      MAT_D:   a = COEF_D_BASE + r * MAX_INPUTS + c;
      default: a = 0;
    endcase
    return CA_W'(a);
  endfunction

endpackage

`default_nettype wire

/* sv/sss_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* sv/sss_ctrl.sv */
// Sequencer that steps the multiply-accumulate datapath through rows and terms.
`timescale 1ns / 1ps
`default_nettype none

module sss_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire sss_pkg::in_item_t  in_data,
  output logic                    in_stall,
  input  wire sss_pkg::dp_stat_t  stat,
  output sss_pkg::dp_cmd_t        cmd
);

  sss_pkg::ctrl_state_t state_r, state_nxt;
  logic                      kind_r, kind_nxt;
  logic [sss_pkg::IX_W-1:0]  row_r, row_nxt;
  logic [sss_pkg::IX_W-1:0]  term_r, term_nxt;
  logic                      phase_r, phase_nxt;
  logic                      drain_r, drain_nxt;

  logic accept;
  logic start;
  logic term_end;
  logic last_row;
  logic y_done;

  assign accept = in_valid && (state_r == sss_pkg::ST_IDLE);
  assign start  = accept && (in_data.opcode == sss_pkg::OP_SAMPLE) && in_data.last_input;

  assign term_end = phase_r
    ? (sss_pkg::CNT_W'(term_r) == stat.m - sss_pkg::CNT_W'(1))
    : (sss_pkg::CNT_W'(term_r) == stat.n - sss_pkg::CNT_W'(1));
  assign last_row = (kind_r == sss_pkg::KIND_X)
    && (sss_pkg::CNT_W'(row_r) == stat.n - sss_pkg::CNT_W'(1));
  assign y_done = (kind_r == sss_pkg::KIND_Y)
    && (sss_pkg::CNT_W'(row_r) == stat.p - sss_pkg::CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sss_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = sss_pkg::ST_ISSUE;
        end
      end
      sss_pkg::ST_ISSUE: begin
        if (phase_r && term_end) begin
          state_nxt = sss_pkg::ST_DRAIN;
        end
      end
      sss_pkg::ST_DRAIN: begin
        if (drain_r) begin
          state_nxt = sss_pkg::ST_FINISH;
        end
      end
      sss_pkg::ST_FINISH: begin
        state_nxt = sss_pkg::ST_EMIT;
      end
      sss_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          state_nxt = last_row ? sss_pkg::ST_COMMIT : sss_pkg::ST_ISSUE;
        end
      end
      sss_pkg::ST_COMMIT: begin
        state_nxt = sss_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sss_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    kind_nxt  = kind_r;
    row_nxt   = row_r;
    term_nxt  = term_r;
    phase_nxt = phase_r;
    drain_nxt = drain_r;
    case (state_r)
      sss_pkg::ST_IDLE: begin
        if (start) begin
          kind_nxt  = (stat.p == '0) ? sss_pkg::KIND_X : sss_pkg::KIND_Y;
          row_nxt   = '0;
          term_nxt  = '0;
          phase_nxt = 1'b0;
        end
      end
      sss_pkg::ST_ISSUE: begin
        if (term_end) begin
          term_nxt = '0;
          if (!phase_r) begin
            phase_nxt = 1'b1;
          end else begin
            drain_nxt = 1'b0;
          end
        end else begin
          term_nxt = term_r + 1'b1;
        end
      end
      sss_pkg::ST_DRAIN: begin
        drain_nxt = 1'b1;
      end
      sss_pkg::ST_EMIT: begin
        if (stat.out_free && !last_row) begin
          term_nxt  = '0;
          phase_nxt = 1'b0;
          if (y_done) begin
            kind_nxt = sss_pkg::KIND_X;
            row_nxt  = '0;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.kind     = kind_r;
    cmd.row      = row_r;
    cmd.term     = term_r;
    cmd.phase_in = phase_r;
    cmd.last     = last_row;
    cmd.accept   = accept;
    in_stall     = (state_r != sss_pkg::ST_IDLE);
    case (state_r)
      sss_pkg::ST_ISSUE: begin
        cmd.issue = 1'b1;
        cmd.clear = (term_r == '0) && !phase_r;
      end
      sss_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
      end
      sss_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
      end
      sss_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sss_pkg::ST_IDLE;
      kind_r  <= sss_pkg::KIND_Y;
      row_r   <= '0;
      term_r  <= '0;
      phase_r <= 1'b0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      row_r   <= row_nxt;
      term_r  <= term_nxt;
      phase_r <= phase_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/sss_dp.sv */
// Datapath: coefficient memory, vectors, multiply-accumulate, saturation, output register.
`timescale 1ns / 1ps
`default_nettype none

module sss_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire sss_pkg::in_item_t              in_data,
  input  wire logic                           cfg_we,
  input  wire logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sss_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire sss_pkg::dp_cmd_t               cmd,
  output sss_pkg::dp_stat_t                   stat,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output sss_pkg::out_item_t                  out_data
);

  localparam int V = sss_pkg::VALUE_BITS;

  logic [3:0] state_count_r, state_count_nxt;
  logic [2:0] input_count_r, input_count_nxt;
  logic [2:0] output_count_r, output_count_nxt;

  logic [sss_pkg::CNT_W-1:0] n, m, p;

  logic signed [V-1:0] x_r [sss_pkg::MAX_STATES];
  logic signed [V-1:0] x_nxt [sss_pkg::MAX_STATES];
  logic signed [V-1:0] xn_r [sss_pkg::MAX_STATES];
  logic signed [V-1:0] u_r [sss_pkg::MAX_INPUTS];
  logic signed [V-1:0] u_nxt [sss_pkg::MAX_INPUTS];
  logic                coef_vld_r [sss_pkg::COEF_DEPTH];

  logic signed [V-1:0]          in_val;
  logic                         wr_ok;
  logic                         coef_we;
  logic [sss_pkg::CA_W-1:0]     waddr;
  logic [1:0]                   rsel;
  logic [sss_pkg::CA_W-1:0]     raddr;
  logic [V-1:0]                 ram_rdata;

  logic                         rd_vld_r;
  logic                         s1_valid_r;
  logic                         s1_phase_r;
  logic [sss_pkg::IX_W-1:0]     s1_term_r;
  logic signed [V-1:0]          coef;
  logic signed [V-1:0]          opnd;
  logic signed [2*V-1:0]        prod_nxt;
  logic signed [2*V-1:0]        prod_r;
  logic                         s2_valid_r;
  logic signed [sss_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic signed [sss_pkg::ACC_W-1:0] sh;
  logic signed [V-1:0]          fin_val_r, fin_val_nxt;
  logic                         fin_sat_r, fin_sat_nxt;

  logic                         out_free;
  logic                         out_load;
  logic                         out_valid_r, out_valid_nxt;
  sss_pkg::out_item_t           out_r;

  // Configuration registers and the counts in effect.
  always_comb begin
    state_count_nxt  = state_count_r;
    input_count_nxt  = input_count_r;
    output_count_nxt = output_count_r;
    if (cfg_we) begin
      case (cfg_index)
        sss_pkg::CFG_STATE_COUNT:  state_count_nxt  = cfg_wdata[3:0];
        sss_pkg::CFG_INPUT_COUNT:  input_count_nxt  = cfg_wdata[2:0];
        sss_pkg::CFG_OUTPUT_COUNT: output_count_nxt = cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (state_count_r == '0) begin
      n = sss_pkg::CNT_W'(1);
    end else if (int'(state_count_r) > sss_pkg::MAX_STATES) begin
      n = sss_pkg::CNT_W'(sss_pkg::MAX_STATES);
    end else begin
      n = sss_pkg::CNT_W'(state_count_r);
    end
    if (input_count_r == '0) begin
      m = sss_pkg::CNT_W'(1);
    end else if (int'(input_count_r) > sss_pkg::MAX_INPUTS) begin
      m = sss_pkg::CNT_W'(sss_pkg::MAX_INPUTS);
    end else begin
      m = sss_pkg::CNT_W'(input_count_r);
    end
    if (int'(output_count_r) > sss_pkg::MAX_OUTPUTS) begin
      p = sss_pkg::CNT_W'(sss_pkg::MAX_OUTPUTS);
    end else begin
      p = sss_pkg::CNT_W'(output_count_r);
    end
  end

  // Load items.
  assign in_val = V'(in_data.value);

  always_comb begin
    case (in_data.matrix_select)
      sss_pkg::MAT_A: wr_ok = (int'(in_data.row) < sss_pkg::MAX_STATES)
                           && (int'(in_data.col) < sss_pkg::MAX_STATES);
      sss_pkg::MAT_B: wr_ok = (int'(in_data.row) < sss_pkg::MAX_STATES)
                           && (int'(in_data.col) < sss_pkg::MAX_INPUTS);
      sss_pkg::MAT_C: wr_ok = (int'(in_data.row) < sss_pkg::MAX_OUTPUTS)
                           && (int'(in_data.col) < sss_pkg::MAX_STATES);
      sss_pkg::MAT_D: wr_ok = (int'(in_data.row) < sss_pkg::MAX_OUTPUTS)
                           && (int'(in_data.col) < sss_pkg::MAX_INPUTS);
      default:        wr_ok = 1'b0;
    endcase
  end

  assign coef_we = cmd.accept && (in_data.opcode == sss_pkg::OP_COEF) && wr_ok;
  assign waddr   = sss_pkg::coef_addr(in_data.matrix_select, int'(in_data.row),
                                      int'(in_data.col));

  always_comb begin
    if (cmd.kind == sss_pkg::KIND_Y) begin
      rsel = cmd.phase_in ? sss_pkg::MAT_D : sss_pkg::MAT_C;
    end else begin
      rsel = cmd.phase_in ? sss_pkg::MAT_B : sss_pkg::MAT_A;
    end
  end

  assign raddr = sss_pkg::coef_addr(rsel, int'(cmd.row), int'(cmd.term));

  sss_ram #(
    .WIDTH (V),
    .DEPTH (sss_pkg::COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (waddr),
    .wdata (in_val),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // State and input vectors.
  always_comb begin
    for (int i = 0; i < sss_pkg::MAX_STATES; i++) begin
      x_nxt[i] = x_r[i];
    end
    for (int i = 0; i < sss_pkg::MAX_INPUTS; i++) begin
      u_nxt[i] = u_r[i];
    end
    if (cmd.accept && (in_data.opcode == sss_pkg::OP_STATE)
        && (int'(in_data.row) < sss_pkg::MAX_STATES)) begin
      x_nxt[sss_pkg::XI_W'(in_data.row)] = in_val;
    end
    if (cmd.accept && (in_data.opcode == sss_pkg::OP_SAMPLE)
        && (int'(in_data.col) < sss_pkg::MAX_INPUTS)) begin
      u_nxt[sss_pkg::UI_W'(in_data.col)] = in_val;
    end
    if (cmd.commit) begin
      for (int i = 0; i < sss_pkg::MAX_STATES; i++) begin
        if (i < int'(n)) begin
          x_nxt[i] = xn_r[i];
        end
      end
    end
  end

  // Multiply-accumulate pipeline.
  assign coef     = rd_vld_r ? $signed(ram_rdata) : '0;
  assign opnd     = s1_phase_r ? u_r[s1_term_r[sss_pkg::UI_W-1:0]]
                               : x_r[s1_term_r[sss_pkg::XI_W-1:0]];
  assign prod_nxt = coef * opnd;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.clear) begin
      acc_nxt = '0;
    end else if (s2_valid_r) begin
      acc_nxt = acc_r + sss_pkg::ACC_W'(prod_r);
    end
  end

  always_comb begin
    sh = acc_r >>> sss_pkg::FRACTION_BITS;
    fin_val_nxt = fin_val_r;
    fin_sat_nxt = fin_sat_r;
    if (cmd.finish) begin
      if (sh > sss_pkg::SAT_HI) begin
        fin_val_nxt = sss_pkg::VAL_MAX;
        fin_sat_nxt = 1'b1;
      end else if (sh < sss_pkg::SAT_LO) begin
        fin_val_nxt = sss_pkg::VAL_MIN;
        fin_sat_nxt = 1'b1;
      end else begin
        fin_val_nxt = V'(sh);
        fin_sat_nxt = 1'b0;
      end
    end
  end

  // Output register.
  assign out_free      = !out_valid_r || !out_stall;
  assign out_load      = cmd.emit && out_free;
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_count_r  <= 4'd1;
      input_count_r  <= 3'd1;
      output_count_r <= 3'd0;
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < sss_pkg::MAX_STATES; i++) begin
        x_r[i] <= '0;
      end
      for (int i = 0; i < sss_pkg::MAX_INPUTS; i++) begin
        u_r[i] <= '0;
      end
      for (int i = 0; i < sss_pkg::COEF_DEPTH; i++) begin
        coef_vld_r[i] <= 1'b0;
      end
    end else begin
      state_count_r  <= state_count_nxt;
      input_count_r  <= input_count_nxt;
      output_count_r <= output_count_nxt;
      s1_valid_r     <= cmd.issue;
      s2_valid_r     <= s1_valid_r;
      out_valid_r    <= out_valid_nxt;
      for (int i = 0; i < sss_pkg::MAX_STATES; i++) begin
        x_r[i] <= x_nxt[i];
      end
      for (int i = 0; i < sss_pkg::MAX_INPUTS; i++) begin
        u_r[i] <= u_nxt[i];
      end
      if (coef_we) begin
        coef_vld_r[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r   <= coef_vld_r[raddr];
    s1_phase_r <= cmd.phase_in;
    s1_term_r  <= cmd.term;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    fin_val_r  <= fin_val_nxt;
    fin_sat_r  <= fin_sat_nxt;
    if (out_load) begin
      out_r.result_kind  <= cmd.kind;
      out_r.result_index <= 3'(cmd.row);
      out_r.result_value <= sss_pkg::FIELD_BITS'(fin_val_r);
      out_r.saturated    <= fin_sat_r;
      out_r.result_last  <= cmd.last;
      if (cmd.kind == sss_pkg::KIND_X) begin
        xn_r[cmd.row[sss_pkg::XI_W-1:0]] <= fin_val_r;
      end
    end
  end

  assign stat.n        = n;
  assign stat.m        = m;
  assign stat.p        = p;
  assign stat.out_free = out_free;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

`default_nettype wire

/* sv/state_space_step.sv */
// Top level of the fixed-point discrete state-space step block.
//
// Channel  Direction  Handshake              Contents
// in       input      in_valid / in_stall    sss_pkg::in_item_t (load or sample item)
// out      output     out_valid / out_stall  sss_pkg::out_item_t (y, then x_next)
// cfg      input      cfg_we                 cfg_index, cfg_wdata (counts n, m, p)
//
// A load item, or a sample element without the last flag, is taken in idle and leaves the input ready.
// A sample element with the last flag starts a step in which every result row
// runs its n + m products one per cycle through the single multiply-accumulate
// unit, then drains, saturates and is registered; a row waits while the output
// register stays full under out_stall.
// Reset is synchronous; it sets the counts to n = 1, m = 1, p = 0 and clears the vectors and coefficient valid bits.
`timescale 1ns / 1ps
`default_nettype none

module state_space_step (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire sss_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output sss_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sss_pkg::CFG_W-1:0]      cfg_wdata
);

  sss_pkg::dp_cmd_t  cmd;
  sss_pkg::dp_stat_t stat;

  sss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sss_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* sv/sss_checker.sv */
// Port-level checker for the state-space step block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

`include "state_space_step_defines.svh"

module sss_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire sss_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire sss_pkg::out_item_t out_data
);

  `SSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "Stalled result changed")
  `SSS_ASSERT_NOW(a_y_not_last, out_valid && (out_data.result_kind == sss_pkg::KIND_Y), !out_data.result_last, "Output element marked as last result")
  `SSS_ASSERT_NOW(a_busy_stall, out_valid && !out_data.result_last, in_stall, "Input taken while a step is still producing results")
  `SSS_ASSERT_NEXT(a_step_start, in_valid && !in_stall && (in_data.opcode == sss_pkg::OP_SAMPLE) && in_data.last_input, in_stall, "Step did not start after the last sample element")
  `SSS_ASSERT_NEXT(a_load_ready, in_valid && !in_stall && ((in_data.opcode != sss_pkg::OP_SAMPLE) || !in_data.last_input), !in_stall, "Load transfer left the input stalled")

endmodule

bind state_space_step sss_checker u_sss_checker (.*);

`default_nettype wire

/* tb/tb_state_space_step.sv */
// Self-checking testbench for the fixed-point discrete state-space step block.
`timescale 1ns / 1ps
`default_nettype none

module tb_state_space_step;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 32;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sss_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sss_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [sss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sss_pkg::CFG_W-1:0] cfg_wdata = '0;

  state_space_step u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow copy of the system: coefficient stores, vectors and counts.
  logic signed [31:0] a_coef [sss_pkg::MAX_STATES][sss_pkg::MAX_STATES];
  logic signed [31:0] b_coef [sss_pkg::MAX_STATES][sss_pkg::MAX_INPUTS];
  logic signed [31:0] c_coef [sss_pkg::MAX_OUTPUTS][sss_pkg::MAX_STATES];
  logic signed [31:0] d_coef [sss_pkg::MAX_OUTPUTS][sss_pkg::MAX_INPUTS];
  logic signed [31:0] x_state [sss_pkg::MAX_STATES];
  logic signed [31:0] u_vec [sss_pkg::MAX_INPUTS];
  logic [3:0] n_reg;
  logic [2:0] m_reg;
  logic [2:0] p_reg;

  sss_pkg::in_item_t pending_items [$];
  sss_pkg::out_item_t expected_results [$];

  int errors = 0;
  int cycles = 0;
  int items_taken = 0;
  int results_seen = 0;
  int updates_done = 0;
  int sat_seen = 0;
  int settings_used = 0;
  bit idle_on = 1'b1;
  bit hold_trigger = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int gap_left = 0;
  int stall_left = 0;

  function automatic logic signed [127:0] wide_mul(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // Returns {saturated, value} after the Q16.16 rescale.
  function automatic logic [32:0] scale_and_clamp(input logic signed [127:0] acc);
    logic signed [127:0] shifted;
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    shifted = acc >>> sss_pkg::FRACTION_BITS;
    hi_lim = sss_pkg::VAL_MAX;
    lo_lim = sss_pkg::VAL_MIN;
    if (shifted > hi_lim) return {1'b1, sss_pkg::VAL_MAX};
    if (shifted < lo_lim) return {1'b1, sss_pkg::VAL_MIN};
    return {1'b0, shifted[31:0]};
  endfunction

  task automatic update_system();
    int n;
    int m;
    int p;
    int total;
    int k;
    logic signed [127:0] acc;
    logic [32:0] y_res [sss_pkg::MAX_OUTPUTS];
    logic [32:0] x_res [sss_pkg::MAX_STATES];
    sss_pkg::out_item_t r;
    n = (n_reg == 0) ? 1
      : ((n_reg > sss_pkg::MAX_STATES) ? sss_pkg::MAX_STATES : int'(n_reg));
    m = (m_reg == 0) ? 1
      : ((m_reg > sss_pkg::MAX_INPUTS) ? sss_pkg::MAX_INPUTS : int'(m_reg));
    p = (p_reg > sss_pkg::MAX_OUTPUTS) ? sss_pkg::MAX_OUTPUTS : int'(p_reg);
    for (int i = 0; i < p; i++) begin
      acc = '0;
      for (int j = 0; j < n; j++) acc = acc + wide_mul(c_coef[i][j], x_state[j]);
      for (int j = 0; j < m; j++) acc = acc + wide_mul(d_coef[i][j], u_vec[j]);
      y_res[i] = scale_and_clamp(acc);
    end
    for (int i = 0; i < n; i++) begin
      acc = '0;
      for (int j = 0; j < n; j++) acc = acc + wide_mul(a_coef[i][j], x_state[j]);
      for (int j = 0; j < m; j++) acc = acc + wide_mul(b_coef[i][j], u_vec[j]);
      x_res[i] = scale_and_clamp(acc);
    end
    total = p + n;
    k = 0;
    for (int i = 0; i < p; i++) begin
      r.result_kind = sss_pkg::KIND_Y;
      r.result_index = 3'(i);
      r.result_value = y_res[i][31:0];
      r.saturated = y_res[i][32];
      r.result_last = (k == total - 1);
      expected_results.push_back(r);
      k++;
    end
    for (int i = 0; i < n; i++) begin
      r.result_kind = sss_pkg::KIND_X;
      r.result_index = 3'(i);
      r.result_value = x_res[i][31:0];
      r.saturated = x_res[i][32];
      r.result_last = (k == total - 1);
      expected_results.push_back(r);
      x_state[i] = x_res[i][31:0];
      k++;
    end
    updates_done++;
  endtask

  task automatic apply_item(input sss_pkg::in_item_t it);
    case (it.opcode)
      sss_pkg::OP_COEF: begin
        case (it.matrix_select)
          sss_pkg::MAT_A: a_coef[it.row][it.col] = it.value;
          sss_pkg::MAT_B: if (it.col < sss_pkg::MAX_INPUTS) b_coef[it.row][it.col] = it.value;
          sss_pkg::MAT_C: if (it.row < sss_pkg::MAX_OUTPUTS) c_coef[it.row][it.col] = it.value;
          default: begin
            if (it.row < sss_pkg::MAX_OUTPUTS && it.col < sss_pkg::MAX_INPUTS)
              d_coef[it.row][it.col] = it.value;
          end
        endcase
      end
      sss_pkg::OP_STATE: x_state[it.row] = it.value;
      sss_pkg::OP_SAMPLE: begin
        if (it.col < sss_pkg::MAX_INPUTS) u_vec[it.col] = it.value;
        if (it.last_input) update_system();
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
  endtask

  // Input side: one transfer per accepted item, random gaps between items while idle_on is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: random stall bursts while idle_on is set, plus one long hold on request.
  always @(posedge clk) begin
    if (hold_trigger && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = 500;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(1, 8) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on each input transfer, compare each result transfer.
  always @(posedge clk) begin
    sss_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        items_taken++;
        apply_item(in_data);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.saturated) sat_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", '0, out_data.result_value);
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_kind !== want.result_kind)
            report_mismatch("result_kind", 32'(want.result_kind),
                            32'(out_data.result_kind));
          if (out_data.result_index !== want.result_index)
            report_mismatch("result_index", 32'(want.result_index),
                            32'(out_data.result_index));
          if (out_data.result_value !== want.result_value)
            report_mismatch("result_value", want.result_value, out_data.result_value);
          if (out_data.saturated !== want.saturated)
            report_mismatch("saturated", 32'(want.saturated), 32'(out_data.saturated));
          if (out_data.result_last !== want.result_last)
            report_mismatch("result_last", 32'(want.result_last),
                            32'(out_data.result_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles with %0d results outstanding.",
               cycles, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_item(input logic [1:0] op, input logic [1:0] sel,
                            input logic [2:0] row, input logic [2:0] col,
                            input logic [31:0] val, input logic last);
    sss_pkg::in_item_t it;
    it.opcode = op;
    it.matrix_select = sel;
    it.row = row;
    it.col = col;
    it.value = val;
    it.last_input = last;
    pending_items.push_back(it);
  endtask

  task automatic wait_quiet(input int settle);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sss_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sss_pkg::CFG_STATE_COUNT: n_reg = data;
      sss_pkg::CFG_INPUT_COUNT: m_reg = data[2:0];
      sss_pkg::CFG_OUTPUT_COUNT: p_reg = data[2:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_sizes(input logic [3:0] n, input logic [3:0] m, input logic [3:0] p);
    wait_quiet(SETTLE_CYCLES);
    write_reg(sss_pkg::CFG_STATE_COUNT, n);
    write_reg(sss_pkg::CFG_INPUT_COUNT, m);
    write_reg(sss_pkg::CFG_OUTPUT_COUNT, p);
    settings_used++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return sss_pkg::VAL_MAX;
          1: return sss_pkg::VAL_MIN;
          2: return '0;
          default: return Q_ONE;
        endcase
      end
      1: return $urandom();
      default: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
    endcase
  endfunction

  // One sample of m elements; a broken one drops or garbles part of the sequence.
  task automatic queue_sample(input int m, input bit broken, inout int counted);
    int mode;
    mode = broken ? $urandom_range(0, 2) : 3;
    for (int j = 0; j < m; j++) begin
      if (mode == 1 && j != m - 1) continue;
      if (mode == 0 && j == m / 2) queue_item(OP_UNUSED, 2'($urandom()), 3'($urandom()),
                                              3'($urandom()), $urandom(), 1'($urandom()));
      queue_item(sss_pkg::OP_SAMPLE, 2'($urandom()), 3'($urandom()), 3'(j), pick_value(),
                 (j == m - 1) && mode != 2);
      counted++;
    end
  endtask

  initial begin
    int counted;
    int phase;
    int m_eff;
    int loads;
    int r;
    logic [3:0] n_w;
    logic [3:0] m_w;
    logic [3:0] p_w;

    for (int i = 0; i < sss_pkg::MAX_STATES; i++) begin
      for (int j = 0; j < sss_pkg::MAX_STATES; j++) a_coef[i][j] = '0;
      for (int j = 0; j < sss_pkg::MAX_INPUTS; j++) b_coef[i][j] = '0;
      x_state[i] = '0;
    end
    for (int i = 0; i < sss_pkg::MAX_OUTPUTS; i++) begin
      for (int j = 0; j < sss_pkg::MAX_STATES; j++) c_coef[i][j] = '0;
      for (int j = 0; j < sss_pkg::MAX_INPUTS; j++) d_coef[i][j] = '0;
    end
    for (int j = 0; j < sss_pkg::MAX_INPUTS; j++) u_vec[j] = '0;
    n_reg = 4'd1;
    m_reg = 3'd1;
    p_reg = 3'd0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: reset sizes, full sizes with extreme values, then zero and out-of-range sizes.
    queue_item(sss_pkg::OP_SAMPLE, sss_pkg::MAT_A, 3'd0, 3'd0, Q_ONE, 1'b1);
    set_sizes(4'd8, 4'd4, 4'd4);
    queue_item(sss_pkg::OP_COEF, sss_pkg::MAT_A, 3'd7, 3'd7, sss_pkg::VAL_MIN, 1'b0);
    queue_item(sss_pkg::OP_COEF, sss_pkg::MAT_B, 3'd7, 3'd3, sss_pkg::VAL_MAX, 1'b1);
    queue_item(sss_pkg::OP_COEF, sss_pkg::MAT_C, 3'd3, 3'd7, sss_pkg::VAL_MAX, 1'b0);
    queue_item(sss_pkg::OP_COEF, sss_pkg::MAT_D, 3'd3, 3'd3, sss_pkg::VAL_MIN, 1'b0);
    queue_item(sss_pkg::OP_COEF, sss_pkg::MAT_A, 3'd0, 3'd0, Q_ONE, 1'b0);
    queue_item(sss_pkg::OP_COEF, sss_pkg::MAT_B, 3'd0, 3'd0, Q_ONE, 1'b0);
    queue_item(sss_pkg::OP_COEF, sss_pkg::MAT_B, 3'd2, 3'd5, 32'h1234_5678, 1'b0);
    queue_item(sss_pkg::OP_COEF, sss_pkg::MAT_C, 3'd6, 3'd1, 32'h1234_5678, 1'b0);
    queue_item(sss_pkg::OP_COEF, sss_pkg::MAT_D, 3'd5, 3'd6, 32'h1234_5678, 1'b0);
    queue_item(sss_pkg::OP_STATE, sss_pkg::MAT_A, 3'd7, 3'd0, sss_pkg::VAL_MIN, 1'b0);
    queue_item(sss_pkg::OP_STATE, sss_pkg::MAT_A, 3'd0, 3'd0, 32'h0003_0000, 1'b0);
    queue_item(OP_UNUSED, sss_pkg::MAT_D, 3'd7, 3'd7, 32'hFFFF_FFFF, 1'b1);
    queue_item(sss_pkg::OP_STATE, sss_pkg::MAT_D, 3'd1, 3'd0, 32'hFFFF_0000, 1'b1);
    queue_item(sss_pkg::OP_SAMPLE, sss_pkg::MAT_A, 3'd0, 3'd7, 32'h0000_ABCD, 1'b0);
    queue_item(sss_pkg::OP_SAMPLE, sss_pkg::MAT_A, 3'd0, 3'd3, sss_pkg::VAL_MAX, 1'b0);
    queue_item(sss_pkg::OP_SAMPLE, sss_pkg::MAT_A, 3'd0, 3'd0, sss_pkg::VAL_MIN, 1'b1);
    queue_item(sss_pkg::OP_SAMPLE, sss_pkg::MAT_A, 3'd0, 3'd1, 32'hFFFD_8000, 1'b1);
    set_sizes(4'd0, 4'd0, 4'd0);
    queue_item(sss_pkg::OP_SAMPLE, sss_pkg::MAT_A, 3'd0, 3'd0, 32'h0002_0000, 1'b1);
    set_sizes(4'd15, 4'd15, 4'd15);
    queue_item(sss_pkg::OP_SAMPLE, sss_pkg::MAT_A, 3'd0, 3'd2, 32'h0000_8000, 1'b1);

    // Random part: each phase picks sizes, loads the stores and runs samples.
    counted = 0;
    phase = 0;
    while (counted < 190) begin
      idle_on = (counted < 150);
      r = $urandom_range(0, 7);
      if (phase == 2 || r == 1) begin
        n_w = 4'd8; m_w = 4'd4; p_w = 4'd4;
      end else if (r == 0) begin
        n_w = 4'd1; m_w = 4'd1; p_w = 4'd0;
      end else if (r == 2) begin
        n_w = 4'($urandom_range(0, 1) ? 0 : $urandom_range(9, 15));
        m_w = 4'($urandom_range(0, 1) ? 0 : $urandom_range(5, 15));
        p_w = 4'($urandom_range(5, 15));
      end else begin
        n_w = 4'($urandom_range(1, 8));
        m_w = 4'($urandom_range(1, 4));
        p_w = 4'($urandom_range(0, 4));
      end
      set_sizes(n_w, m_w, p_w);
      m_eff = (m_reg == 0) ? 1
        : ((m_reg > sss_pkg::MAX_INPUTS) ? sss_pkg::MAX_INPUTS : int'(m_reg));

      loads = $urandom_range(3, 10);
      for (int k = 0; k < loads; k++) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          queue_item(sss_pkg::OP_COEF, 2'($urandom()), 3'($urandom()), 3'($urandom()),
                     pick_value(), 1'($urandom()));
          counted++;
        end else if (r < 9) begin
          queue_item(sss_pkg::OP_STATE, 2'($urandom()), 3'($urandom()), 3'($urandom()),
                     pick_value(), 1'($urandom()));
          counted++;
        end else begin
          queue_item(OP_UNUSED, 2'($urandom()), 3'($urandom()), 3'($urandom()),
                     $urandom(), 1'($urandom()));
        end
      end

      if (phase == 2) begin
        // Results back up behind a long receiver hold while samples keep coming.
        hold_trigger = 1'b1;
        for (int s = 0; s < 4; s++) queue_sample(m_eff, 1'b0, counted);
      end else begin
        for (int s = $urandom_range(1, 3); s > 0; s--) begin
          queue_sample(m_eff, $urandom_range(0, 5) == 0, counted);
          if ($urandom_range(0, 3) == 0) wait_quiet(0);
        end
      end
      phase++;
    end

    wait_quiet(200);
    $display("Covered %0d input transfers, %0d state updates, %0d result transfers.",
             items_taken, updates_done, results_seen);
    $display("Size settings applied: %0d; saturated results observed: %0d.",
             settings_used, sat_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
